FILE: sv/hsd_pkg.sv
// shared types and constants for the huffman stream decoder
package hsd_pkg;

  localparam int SYMBOL_COUNT   = 256;
  localparam int SIZE_BYTES_DEF = 8;
  localparam int SYM_W          = 8;
  localparam int IDX_W          = 8;
  localparam int WT_W           = 16;
  localparam int CNT_W          = 9;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FEW   = 2'd1;
  localparam logic [1:0] ST_EARLY = 2'd2;

  // reference to a child: a symbol when leaf, else an internal node index
  typedef struct packed {
    logic             leaf;
    logic [IDX_W-1:0] val;
  } hsd_link_t;

  // internal tree node
  typedef struct packed {
    hsd_link_t zero;
    hsd_link_t one;
  } hsd_node_t;

  localparam int NODE_W = $bits(hsd_node_t);

  // heap entry carries the weight next to the link
  typedef struct packed {
    logic [WT_W-1:0] wt;
    hsd_link_t       link;
  } hsd_heap_ent_t;

  localparam int HEAP_W = $bits(hsd_heap_ent_t);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    hsd_node_t        data;
  } hsd_node_wr_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [SYM_W-1:0] data;
  } hsd_wt_wr_t;

  typedef struct packed {
    logic             done;
    logic             bad;
    logic [IDX_W-1:0] root;
  } hsd_build_sts_t;

endpackage

FILE: sv/hsd_ram.sv
// generic single write port ram with registered read
module hsd_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/hsd_tree_build.sv
// tree builder: weight scan, min-heap sequencer and node merging
module hsd_tree_build (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic [hsd_pkg::IDX_W-1:0]     wt_raddr,
  input  logic [hsd_pkg::SYM_W-1:0]     wt_rdata,
  output hsd_pkg::hsd_node_wr_t         node_wr,
  output hsd_pkg::hsd_build_sts_t       sts
);
  import hsd_pkg::*;

  typedef enum logic [12:0] {
    B_IDLE    = 13'b0000000000001,
    B_SC_RD   = 13'b0000000000010,
    B_SC_CHK  = 13'b0000000000100,
    B_SU_RD   = 13'b0000000001000,
    B_SU_CMP  = 13'b0000000010000,
    B_MG_CHK  = 13'b0000000100000,
    B_PO_RD0  = 13'b0000001000000,
    B_PO_RD1  = 13'b0000010000000,
    B_PO_GET  = 13'b0000100000000,
    B_SD_RL   = 13'b0001000000000,
    B_SD_RR   = 13'b0010000000000,
    B_SD_CR   = 13'b0100000000000,
    B_MG_NODE = 13'b1000000000000
  } bstate_t;

  bstate_t       state_r, state_nxt;
  logic [CNT_W-1:0] s_r, s_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] best_r, best_nxt;
  hsd_heap_ent_t cur_r, cur_nxt;
  hsd_heap_ent_t a_r, a_nxt;
  hsd_heap_ent_t b_r, b_nxt;
  hsd_heap_ent_t bestv_r, bestv_nxt;
  logic          in_merge_r, in_merge_nxt;
  logic          pop_b_r, pop_b_nxt;
  logic          done_r, done_nxt;
  logic          bad_r, bad_nxt;
  logic [IDX_W-1:0] root_r, root_nxt;

  // heap memory port signals
  logic             h_we;
  logic [IDX_W-1:0] h_waddr;
  hsd_heap_ent_t    h_wdata;
  logic [IDX_W-1:0] h_raddr;
  logic [HEAP_W-1:0] h_rbits;
  hsd_heap_ent_t    h_rdata;

  // sift-down helpers
  logic [CNT_W-1:0] l_idx;
  logic [CNT_W-1:0] r_idx;
  logic             l_take;
  logic             r_take;
  logic             pop_done;

  assign h_rdata  = hsd_heap_ent_t'(h_rbits);
  assign l_idx    = {i_r, 1'b0};
  assign r_idx    = {i_r, 1'b1};
  assign wt_raddr = s_r[IDX_W-1:0];

  assign sts.done = done_r;
  assign sts.bad  = bad_r;
  assign sts.root = root_r;

  hsd_ram #(
    .W(HEAP_W),
    .D(SYMBOL_COUNT)
  ) u_heap (
    .clk  (clk),
    .we   (h_we),
    .waddr(h_waddr),
    .wdata(h_wdata),
    .raddr(h_raddr),
    .rdata(h_rbits)
  );

  // build sequencer
  always_comb begin
    state_nxt    = state_r;
    s_nxt        = s_r;
    cnt_nxt      = cnt_r;
    i_nxt        = i_r;
    k_nxt        = k_r;
    best_nxt     = best_r;
    cur_nxt      = cur_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    bestv_nxt    = bestv_r;
    in_merge_nxt = in_merge_r;
    pop_b_nxt    = pop_b_r;
    done_nxt     = 1'b0;
    bad_nxt      = bad_r;
    root_nxt     = root_r;
    h_we         = 1'b0;
    h_waddr      = i_r;
    h_wdata      = cur_r;
    h_raddr      = '0;
    node_wr      = '0;
    l_take       = 1'b0;
    r_take       = 1'b0;
    pop_done     = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (start) begin
          s_nxt        = '0;
          cnt_nxt      = '0;
          k_nxt        = '0;
          in_merge_nxt = 1'b0;
          state_nxt    = B_SC_RD;
        end
      end
      B_SC_RD: begin
        if (s_r == CNT_W'(SYMBOL_COUNT)) begin
          if (cnt_r < CNT_W'(2)) begin
            bad_nxt   = 1'b1;
            root_nxt  = '0;
            done_nxt  = 1'b1;
            state_nxt = B_IDLE;
          end else begin
            in_merge_nxt = 1'b1;
            state_nxt    = B_MG_CHK;
          end
        end else begin
          state_nxt = B_SC_CHK;
        end
      end
      B_SC_CHK: begin
        s_nxt = s_r + CNT_W'(1);
        if (wt_rdata != '0) begin
          cur_nxt.wt        = WT_W'(wt_rdata);
          cur_nxt.link.leaf = 1'b1;
          cur_nxt.link.val  = s_r[IDX_W-1:0];
          i_nxt             = cnt_r[IDX_W-1:0];
          cnt_nxt           = cnt_r + CNT_W'(1);
          state_nxt         = B_SU_RD;
        end else begin
          state_nxt = B_SC_RD;
        end
      end
      B_SU_RD: begin
        if (i_r == '0) begin
          h_we      = 1'b1;
          h_waddr   = '0;
          h_wdata   = cur_r;
          state_nxt = in_merge_r ? B_MG_CHK : B_SC_RD;
        end else begin
          h_raddr   = i_r >> 1;
          state_nxt = B_SU_CMP;
        end
      end
      B_SU_CMP: begin
        h_we    = 1'b1;
        h_waddr = i_r;
        if (cur_r.wt < h_rdata.wt) begin
          h_wdata   = h_rdata;
          i_nxt     = i_r >> 1;
          state_nxt = B_SU_RD;
        end else begin
          h_wdata   = cur_r;
          state_nxt = in_merge_r ? B_MG_CHK : B_SC_RD;
        end
      end
      B_MG_CHK: begin
        if (cnt_r > CNT_W'(1)) begin
          pop_b_nxt = 1'b0;
          state_nxt = B_PO_RD0;
        end else begin
          root_nxt  = k_r - IDX_W'(1);
          bad_nxt   = 1'b0;
          done_nxt  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      B_PO_RD0: begin
        h_raddr   = '0;
        state_nxt = B_PO_RD1;
      end
      B_PO_RD1: begin
        if (pop_b_r) begin
          b_nxt = h_rdata;
        end else begin
          a_nxt = h_rdata;
        end
        h_raddr = IDX_W'(cnt_r - CNT_W'(1));
        if (cnt_r > CNT_W'(1)) begin
          state_nxt = B_PO_GET;
        end else begin
          cnt_nxt  = cnt_r - CNT_W'(1);
          pop_done = 1'b1;
        end
      end
      B_PO_GET: begin
        cur_nxt   = h_rdata;
        cnt_nxt   = cnt_r - CNT_W'(1);
        i_nxt     = '0;
        state_nxt = B_SD_RL;
      end
      B_SD_RL: begin
        h_raddr   = l_idx[IDX_W-1:0];
        state_nxt = B_SD_RR;
      end
      B_SD_RR: begin
        l_take    = (l_idx < cnt_r) && (l_idx != {1'b0, i_r}) && (h_rdata.wt < cur_r.wt);
        best_nxt  = l_take ? l_idx[IDX_W-1:0] : i_r;
        bestv_nxt = l_take ? h_rdata : cur_r;
        h_raddr   = r_idx[IDX_W-1:0];
        state_nxt = B_SD_CR;
      end
      B_SD_CR: begin
        r_take  = (r_idx < cnt_r) && (h_rdata.wt < bestv_r.wt);
        h_we    = 1'b1;
        h_waddr = i_r;
        if (!r_take && best_r == i_r) begin
          h_wdata  = cur_r;
          pop_done = 1'b1;
        end else begin
          h_wdata   = r_take ? h_rdata : bestv_r;
          i_nxt     = r_take ? r_idx[IDX_W-1:0] : best_r;
          state_nxt = B_SD_RL;
        end
      end
      B_MG_NODE: begin
        node_wr.we        = 1'b1;
        node_wr.addr      = k_r;
        node_wr.data.zero = a_r.link;
        node_wr.data.one  = b_r.link;
        cur_nxt.wt        = a_r.wt + b_r.wt;
        cur_nxt.link.leaf = 1'b0;
        cur_nxt.link.val  = k_r;
        i_nxt             = cnt_r[IDX_W-1:0];
        cnt_nxt           = cnt_r + CNT_W'(1);
        k_nxt             = k_r + IDX_W'(1);
        state_nxt         = B_SU_RD;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    // after a pop: take the second one or merge the pair
    if (pop_done) begin
      if (!pop_b_r) begin
        pop_b_nxt = 1'b1;
        state_nxt = B_PO_RD0;
      end else begin
        state_nxt = B_MG_NODE;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      in_merge_r <= 1'b0;
      pop_b_r    <= 1'b0;
      done_r     <= 1'b0;
      bad_r      <= 1'b0;
      root_r     <= '0;
      s_r        <= '0;
      cnt_r      <= '0;
      k_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      in_merge_r <= in_merge_nxt;
      pop_b_r    <= pop_b_nxt;
      done_r     <= done_nxt;
      bad_r      <= bad_nxt;
      root_r     <= root_nxt;
      s_r        <= s_nxt;
      cnt_r      <= cnt_nxt;
      k_r        <= k_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    best_r  <= best_nxt;
    cur_r   <= cur_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    bestv_r <= bestv_nxt;
  end

endmodule

FILE: sv/hsd_ctrl.sv
// stream control: header capture, bit walk over the tree and result queue
module hsd_ctrl #(
  parameter int SIZE_BYTES = hsd_pkg::SIZE_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte,
  input  logic                          in_end_of_stream,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_symbol,
  output logic                          out_last_in_run,
  output logic                          out_message_done,
  output logic [1:0]                    out_status,
  output hsd_pkg::hsd_wt_wr_t           wt_wr,
  output logic                          build_start,
  input  hsd_pkg::hsd_build_sts_t       build_sts,
  output logic [hsd_pkg::IDX_W-1:0]     node_raddr,
  input  logic [hsd_pkg::NODE_W-1:0]    node_rdata
);
  import hsd_pkg::*;

  localparam int LEN_W      = 8 * SIZE_BYTES;
  localparam int HEADER_LEN = SIZE_BYTES + SYMBOL_COUNT;

  typedef enum logic [4:0] {
    C_IDLE  = 5'b00001,
    C_BUILD = 5'b00010,
    C_DEC   = 5'b00100,
    C_FIN1  = 5'b01000,
    C_FIN2  = 5'b10000
  } cstate_t;

  cstate_t          state_r, state_nxt;
  logic [CNT_W-1:0] hcnt_r, hcnt_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic             bad_r, bad_nxt;
  logic [IDX_W-1:0] root_r, root_nxt;
  logic [IDX_W-1:0] walk_r, walk_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             eos_r, eos_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic [3:0]       nres_r, nres_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [7:0]       pend_sym_r, pend_sym_nxt;
  logic             pend_done_r, pend_done_nxt;
  logic [1:0]       pend_st_r, pend_st_nxt;
  logic             out_v_r, out_v_nxt;
  logic [7:0]       out_sym_r, out_sym_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_done_r, out_done_nxt;
  logic [1:0]       out_st_r, out_st_nxt;

  logic             accept;
  logic             out_free;
  logic             push;
  logic             push_last;
  logic             early;
  logic             can_go;
  logic             finish;
  hsd_node_t        node;
  hsd_link_t        child;

  assign node       = hsd_node_t'(node_rdata);
  assign child      = byte_r[3'd7 - bit_r] ? node.one : node.zero;
  assign in_stall   = (state_r != C_IDLE);
  assign accept     = in_valid && (state_r == C_IDLE);
  assign out_free   = !out_v_r || !out_stall;
  assign can_go     = !pend_v_r || out_free;
  assign early      = (hcnt_r < CNT_W'(HEADER_LEN)) || (!bad_r && rem_r != '0);
  assign node_raddr = walk_nxt;

  assign out_valid        = out_v_r;
  assign out_symbol       = out_sym_r;
  assign out_last_in_run  = out_last_r;
  assign out_message_done = out_done_r;
  assign out_status       = out_st_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    hcnt_nxt      = hcnt_r;
    len_nxt       = len_r;
    rem_nxt       = rem_r;
    bad_nxt       = bad_r;
    root_nxt      = root_r;
    walk_nxt      = walk_r;
    byte_nxt      = byte_r;
    eos_nxt       = eos_r;
    bit_nxt       = bit_r;
    nres_nxt      = nres_r;
    pend_v_nxt    = pend_v_r;
    pend_sym_nxt  = pend_sym_r;
    pend_done_nxt = pend_done_r;
    pend_st_nxt   = pend_st_r;
    push          = 1'b0;
    push_last     = 1'b0;
    finish        = 1'b0;
    wt_wr         = '0;
    build_start   = 1'b0;

    unique case (state_r)
      C_IDLE: begin
        if (accept) begin
          byte_nxt = in_byte;
          eos_nxt  = in_end_of_stream;
          bit_nxt  = '0;
          nres_nxt = '0;
          if (hcnt_r < CNT_W'(HEADER_LEN)) begin
            // header byte: length lane or weight
            if (hcnt_r < CNT_W'(SIZE_BYTES)) begin
              for (int j = 0; j < SIZE_BYTES; j++) begin
                if (hcnt_r == CNT_W'(j)) begin
                  len_nxt[8*j +: 8] = in_byte;
                end
              end
            end else begin
              wt_wr.we   = 1'b1;
              wt_wr.addr = IDX_W'(hcnt_r - CNT_W'(SIZE_BYTES));
              wt_wr.data = in_byte;
            end
            hcnt_nxt = hcnt_r + CNT_W'(1);
            if (hcnt_r == CNT_W'(HEADER_LEN - 1)) begin
              rem_nxt     = len_r;
              build_start = 1'b1;
              state_nxt   = C_BUILD;
            end else begin
              state_nxt = C_FIN1;
            end
          end else if (!bad_r) begin
            state_nxt = C_DEC;
          end else begin
            state_nxt = C_FIN1;
          end
        end
      end
      C_BUILD: begin
        if (build_sts.done) begin
          bad_nxt  = build_sts.bad;
          root_nxt = build_sts.root;
          walk_nxt = build_sts.root;
          if (build_sts.bad) begin
            pend_v_nxt    = 1'b1;
            pend_sym_nxt  = '0;
            pend_done_nxt = 1'b0;
            pend_st_nxt   = ST_FEW;
            nres_nxt      = 4'd1;
          end
          state_nxt = C_FIN1;
        end
      end
      C_DEC: begin
        // one tree step per bit, msb first
        if (rem_r == '0) begin
          state_nxt = C_FIN1;
        end else if (can_go) begin
          if (child.leaf) begin
            push          = pend_v_r;
            pend_v_nxt    = 1'b1;
            pend_sym_nxt  = child.val;
            pend_done_nxt = (rem_r == LEN_W'(1));
            pend_st_nxt   = ST_OK;
            rem_nxt       = rem_r - LEN_W'(1);
            nres_nxt      = nres_r + 4'd1;
            walk_nxt      = root_r;
          end else begin
            walk_nxt = child.val;
          end
          bit_nxt = bit_r + 3'd1;
          if (bit_r == 3'd7) begin
            state_nxt = C_FIN1;
          end
        end
      end
      C_FIN1: begin
        // early end appends an error, or replaces a full run's last symbol
        if (eos_r && early) begin
          if (nres_r == 4'd8 || !pend_v_r || out_free) begin
            push          = pend_v_r && (nres_r != 4'd8);
            pend_v_nxt    = 1'b1;
            pend_sym_nxt  = '0;
            pend_done_nxt = 1'b0;
            pend_st_nxt   = ST_EARLY;
            state_nxt     = C_FIN2;
          end
        end else begin
          state_nxt = C_FIN2;
        end
      end
      C_FIN2: begin
        if (!pend_v_r) begin
          finish = 1'b1;
        end else if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          pend_v_nxt = 1'b0;
          finish     = 1'b1;
        end
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase

    // close the byte, and the stream on its final byte
    if (finish) begin
      state_nxt = C_IDLE;
      if (eos_r) begin
        hcnt_nxt = '0;
        len_nxt  = '0;
        rem_nxt  = '0;
        bad_nxt  = 1'b0;
        root_nxt = '0;
        walk_nxt = '0;
      end
    end
  end

  // output register
  always_comb begin
    out_v_nxt    = out_v_r;
    out_sym_nxt  = out_sym_r;
    out_last_nxt = out_last_r;
    out_done_nxt = out_done_r;
    out_st_nxt   = out_st_r;
    if (push) begin
      out_v_nxt    = 1'b1;
      out_sym_nxt  = pend_sym_r;
      out_last_nxt = push_last;
      out_done_nxt = pend_done_r;
      out_st_nxt   = pend_st_r;
    end else if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= C_IDLE;
      hcnt_r   <= '0;
      len_r    <= '0;
      rem_r    <= '0;
      bad_r    <= 1'b0;
      root_r   <= '0;
      walk_r   <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      eos_r    <= 1'b0;
      bit_r    <= '0;
      nres_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      hcnt_r   <= hcnt_nxt;
      len_r    <= len_nxt;
      rem_r    <= rem_nxt;
      bad_r    <= bad_nxt;
      root_r   <= root_nxt;
      walk_r   <= walk_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      eos_r    <= eos_nxt;
      bit_r    <= bit_nxt;
      nres_r   <= nres_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    pend_sym_r  <= pend_sym_nxt;
    pend_done_r <= pend_done_nxt;
    pend_st_r   <= pend_st_nxt;
    out_sym_r   <= out_sym_nxt;
    out_last_r  <= out_last_nxt;
    out_done_r  <= out_done_nxt;
    out_st_r    <= out_st_nxt;
  end

endmodule

FILE: sv/huffman_stream_decoder.sv
// top level of the huffman stream decoder
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  in_byte, in_end_of_stream
//  out_     output     out_valid/out_stall  out_symbol, out_last_in_run,
//                                           out_message_done, out_status
//
// a header byte passes through C_FIN1 and C_FIN2; a payload byte walks one tree
// step per bit in C_DEC (up to eight, one node memory read each) until the declared
// length is reached, then C_FIN1 and C_FIN2, and waits while out_stall holds.
// the last header byte starts the tree build (scan: B_SC_RD, B_SC_CHK per weight;
// sift-up: B_SU_RD, B_SU_CMP per level; sift-down: B_SD_RL, B_SD_RR, B_SD_CR).
// rst_n is synchronous; after reset the block waits for a new header.
// a stall on out_ holds the bit walk; in_stall stays high until a byte is finished.
module huffman_stream_decoder #(
  parameter int SIZE_BYTES = hsd_pkg::SIZE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_stream,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_symbol,
  output logic       out_last_in_run,
  output logic       out_message_done,
  output logic [1:0] out_status
);
  import hsd_pkg::*;

  hsd_wt_wr_t       wt_wr;
  logic [IDX_W-1:0] wt_raddr;
  logic [SYM_W-1:0] wt_rdata;
  hsd_node_wr_t     node_wr;
  logic [IDX_W-1:0] node_raddr;
  logic [NODE_W-1:0] node_rdata;
  logic             build_start;
  hsd_build_sts_t   build_sts;

  // symbol weights
  hsd_ram #(
    .W(SYM_W),
    .D(SYMBOL_COUNT)
  ) u_wt_ram (
    .clk  (clk),
    .we   (wt_wr.we),
    .waddr(wt_wr.addr),
    .wdata(wt_wr.data),
    .raddr(wt_raddr),
    .rdata(wt_rdata)
  );

  // internal tree nodes
  hsd_ram #(
    .W(NODE_W),
    .D(SYMBOL_COUNT)
  ) u_node_ram (
    .clk  (clk),
    .we   (node_wr.we),
    .waddr(node_wr.addr),
    .wdata(node_wr.data),
    .raddr(node_raddr),
    .rdata(node_rdata)
  );

  hsd_tree_build u_build (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (build_start),
    .wt_raddr(wt_raddr),
    .wt_rdata(wt_rdata),
    .node_wr (node_wr),
    .sts     (build_sts)
  );

  hsd_ctrl #(
    .SIZE_BYTES(SIZE_BYTES)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_stream(in_end_of_stream),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_symbol      (out_symbol),
    .out_last_in_run (out_last_in_run),
    .out_message_done(out_message_done),
    .out_status      (out_status),
    .wt_wr           (wt_wr),
    .build_start     (build_start),
    .build_sts       (build_sts),
    .node_raddr      (node_raddr),
    .node_rdata      (node_rdata)
  );

endmodule

FILE: tb/huffman_stream_decoder_tb.sv
// testbench for the huffman stream decoder: directed and random streams against a predictor
`timescale 1ns / 1ps

module huffman_stream_decoder_tb;
  import hsd_pkg::*;

  localparam int NBYTES   = SIZE_BYTES_DEF;
  localparam int HDR_LEN  = NBYTES + SYMBOL_COUNT;
  localparam int NODE_CNT = 2 * SYMBOL_COUNT - 1;
  localparam int IDLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
    logic       done;
    logic [1:0] status;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = '0;
  logic       in_end_of_stream = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_symbol;
  logic       out_last_in_run;
  logic       out_message_done;
  logic [1:0] out_status;

  huffman_stream_decoder u_top (.*);

  always #5 clk = ~clk;

  // decoder state mirror
  int              hdr_cnt;
  longint unsigned msg_len, sym_cnt;
  int              weights [SYMBOL_COUNT];
  int              heap [SYMBOL_COUNT];
  int              heap_len;
  int              nd_sym [NODE_CNT];
  int              nd_wt [NODE_CNT];
  int              nd_zero [NODE_CNT];
  int              nd_one [NODE_CNT];
  bit              nd_leaf [NODE_CNT];
  int              root_node, cur_node;
  bit              few_syms;

  decoded_t symbol_q[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  int       burst_left = 0;
  int       hdr_wts [SYMBOL_COUNT];

  function automatic bit heap_lighter(int a, int b);
    return nd_wt[heap[b % SYMBOL_COUNT] % NODE_CNT] < nd_wt[heap[a % SYMBOL_COUNT] % NODE_CNT];
  endfunction

  function automatic void heap_swap(int x, int y);
    int t;
    t = heap[x % SYMBOL_COUNT];
    heap[x % SYMBOL_COUNT] = heap[y % SYMBOL_COUNT];
    heap[y % SYMBOL_COUNT] = t;
  endfunction

  function automatic void heap_up();
    int i, p;
    if (heap_len == 0) return;
    i = heap_len - 1;
    forever begin
      p = i >> 1;
      if (heap_lighter(p, i)) begin
        heap_swap(p, i);
        i = p;
      end else break;
    end
  endfunction

  function automatic int heap_pop();
    int top, i, l, r, best;
    top = heap[0];
    if (heap_len > 1) heap_swap(0, heap_len - 1);
    heap_len--;
    i = 0;
    while (i < heap_len) begin
      l = i << 1;
      r = l + 1;
      best = i;
      if (l < heap_len && heap_lighter(best, l)) best = l;
      if (r < heap_len && heap_lighter(best, r)) best = r;
      if (best == i) break;
      heap_swap(i, best);
      i = best;
    end
    return top;
  endfunction

  function automatic void build_code_tree();
    int used, a, b, k;
    used = 0;
    heap_len = 0;
    for (int s = 0; s < SYMBOL_COUNT; s++) begin
      if (weights[s] != 0) begin
        nd_sym[used] = s;
        nd_wt[used] = weights[s];
        nd_zero[used] = 0;
        nd_one[used] = 0;
        nd_leaf[used] = 1'b1;
        heap[heap_len] = used;
        heap_len++;
        used++;
        heap_up();
      end
    end
    if (heap_len < 2) begin
      few_syms = 1'b1;
      root_node = 0;
      cur_node = 0;
      return;
    end
    while (heap_len > 1) begin
      a = heap_pop() % NODE_CNT;
      b = heap_pop() % NODE_CNT;
      k = used % NODE_CNT;
      nd_sym[k] = 0;
      nd_wt[k] = (nd_wt[a] + nd_wt[b]) & 16'hFFFF;
      nd_zero[k] = a;
      nd_one[k] = b;
      nd_leaf[k] = 1'b0;
      heap[heap_len] = k;
      heap_len++;
      used++;
      heap_up();
    end
    root_node = heap[0] % NODE_CNT;
    cur_node = root_node;
  endfunction

  // work out the results of one accepted request
  function automatic void decode_request(logic [7:0] b, logic eos);
    decoded_t res[$];
    decoded_t d;
    if (hdr_cnt < HDR_LEN) begin
      if (hdr_cnt < NBYTES) msg_len |= longint'(b) << (8 * hdr_cnt);
      else weights[hdr_cnt - NBYTES] = b;
      hdr_cnt++;
      if (hdr_cnt == HDR_LEN) begin
        build_code_tree();
        if (few_syms) res.push_back('{8'd0, 1'b0, 1'b0, ST_FEW});
      end
    end else if (!few_syms) begin
      for (int i = 0; i < 8; i++) begin
        if (sym_cnt >= msg_len) break;
        cur_node = (b[7-i] ? nd_one[cur_node] : nd_zero[cur_node]) % NODE_CNT;
        if (nd_leaf[cur_node]) begin
          sym_cnt++;
          res.push_back('{nd_sym[cur_node][7:0], 1'b0, sym_cnt == msg_len, ST_OK});
          cur_node = root_node;
        end
      end
    end
    if (eos) begin
      if (hdr_cnt < HDR_LEN || (!few_syms && sym_cnt < msg_len)) begin
        if (res.size() >= 8) void'(res.pop_back());
        res.push_back('{8'd0, 1'b0, 1'b0, ST_EARLY});
      end
      hdr_cnt = 0;
      msg_len = 0;
      sym_cnt = 0;
      root_node = 0;
      cur_node = 0;
      few_syms = 1'b0;
    end
    if (res.size() > 0) begin
      d = res.pop_back();
      d.last = 1'b1;
      res.push_back(d);
    end
    foreach (res[i]) symbol_q.push_back(res[i]);
  endfunction

  // send one request, with bursts and gaps
  task automatic send_byte(logic [7:0] b, logic eos);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 4) == 0 ? $urandom_range(1, 12) : $urandom_range(0, 2))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte <= b;
    in_end_of_stream <= eos;
    do @(posedge clk); while (in_stall);
    decode_request(b, eos);
  endtask

  task automatic send_header(longint unsigned len);
    for (int i = 0; i < NBYTES; i++) send_byte(len[8*i +: 8], 1'b0);
    for (int s = 0; s < SYMBOL_COUNT; s++) send_byte(hdr_wts[s][7:0], 1'b0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (symbol_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // two equal weights: every bit is a symbol
  task automatic set_two_syms();
    foreach (hdr_wts[s]) hdr_wts[s] = 0;
    hdr_wts[3] = 1;
    hdr_wts[200] = 1;
  endtask

  task automatic test_few_symbols();
    foreach (hdr_wts[s]) hdr_wts[s] = 0;
    hdr_wts[255] = 255;
    send_header(64'd5);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    foreach (hdr_wts[s]) hdr_wts[s] = 0;
    send_header(64'd0);
    send_byte(8'h5A, 1'b1);
  endtask

  task automatic test_zero_length();
    set_two_syms();
    send_header(64'd0);
    send_byte(8'hC3, 1'b1);
  endtask

  task automatic test_padding();
    set_two_syms();
    send_header(64'd10);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h81, 1'b1);
  endtask

  task automatic test_full_run_early();
    set_two_syms();
    send_header(64'hFFFF_FFFF_FFFF_FFFF);
    send_byte(8'hA5, 1'b1);
  endtask

  task automatic test_early_header();
    send_byte(8'h12, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    drain();
  endtask

  task automatic test_random_streams();
    int mode, pay;
    longint unsigned len;
    for (int n = 0; n < 6; n++) begin
      mode = n % 3;
      foreach (hdr_wts[s]) begin
        case (mode)
          0: hdr_wts[s] = $urandom_range(1, 255);
          1: hdr_wts[s] = ($urandom_range(0, 40) == 0) ? $urandom_range(1, 3) : 0;
          default: hdr_wts[s] = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 255) : 0;
        endcase
      end
      len = $urandom_range(0, 45);
      send_header(len);
      if (n == 2) begin
        // let everything come out before the payload
        drain();
      end
      pay = 0;
      while (sym_cnt < msg_len && !few_syms && pay < 80 && !(n == 4 && pay == 3)) begin
        send_byte(8'($urandom), 1'b0);
        pay++;
      end
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b1);
    end
  endtask

  // receiver stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    case ((stall_phase >> 6) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ((stall_phase % 16) < 5);
      default: out_stall <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (symbol_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result sym=%0h last=%0b done=%0b status=%0d",
                   out_symbol, out_last_in_run, out_message_done, out_status);
      end else begin
        want = symbol_q.pop_front();
        if (out_symbol !== want.sym || out_last_in_run !== want.last ||
            out_message_done !== want.done || out_status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp sym=%0h last=%0b done=%0b status=%0d, got %0h %0b %0b %0d",
                     want.sym, want.last, want.done, want.status,
                     out_symbol, out_last_in_run, out_message_done, out_status);
        end
      end
    end
  end

  // watchdog on cycles with no request accepted and no result taken
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[huffman_stream_decoder] ERROR");
      $finish;
    end
  end

  initial begin
    hdr_cnt = 0;
    msg_len = 0;
    sym_cnt = 0;
    root_node = 0;
    cur_node = 0;
    few_syms = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_early_header();
    test_few_symbols();
    test_zero_length();
    test_padding();
    test_full_run_early();
    test_random_streams();
    drain();
    if (mismatches == 0 && symbol_q.size() == 0) begin
      $display("[huffman_stream_decoder] OK");
    end else begin
      $display("[huffman_stream_decoder] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/hsd_pkg.sv
sv/hsd_ram.sv
sv/hsd_tree_build.sv
sv/hsd_ctrl.sv
sv/huffman_stream_decoder.sv
tb/huffman_stream_decoder_tb.sv
